/* src/kvt_pkg.sv */
package kvt_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int REQ_W   = 2;
    localparam int COUNT_W = 5;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } kvt_state_t;

    typedef struct packed {
        logic load;    // capture request beat, restart scan
        logic scan;    // advance slot sweep
        logic commit;  // update table, load result register
    } kvt_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } kvt_stat_t;

endpackage

/* src/kvt_ctrl.sv */
module kvt_ctrl
    import kvt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  kvt_stat_t stat,
    output kvt_cmd_t  cmd
);

    kvt_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (stat.scan_done) state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!stat.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_COMMIT: begin
                cmd.commit = !stat.out_busy;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* src/kvt_datapath.sv */
module kvt_datapath
    import kvt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  kvt_cmd_t             cmd,
    output kvt_stat_t            stat,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [KEY_W-1:0]     key,
    input  logic [VALUE_W-1:0]   value_in,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [VALUE_W-1:0]   value_out,
    output logic                 found,
    output logic                 status,
    output logic [COUNT_W-1:0]   entry_count,
    output logic                 is_empty
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_W = KEY_W + VALUE_W;
    localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(TABLE_ENTRIES);

    // key in low half, value in high half
    logic [SLOT_W-1:0]        slot_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]         count_reg, count_next;

    logic [REQ_W-1:0]   req_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] val_reg;

    // sweep: issue read, then compare in the next cycle
    logic [CNT_W-1:0]  addr_reg;
    logic              pend_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [SLOT_W-1:0] rd_data_reg;
    logic              rd_vld_reg;

    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [VALUE_W-1:0] hit_val_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_found_reg;
    logic               out_status_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_empty_reg;

    logic               issue;
    logic               is_ins, is_rem, is_known;
    logic               wr_en, set_valid, clr_valid;
    logic [IDX_W-1:0]   wr_idx;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;

    assign issue = cmd.scan && (addr_reg != LAST_ADDR);

    assign stat.scan_done = (addr_reg == LAST_ADDR) && !pend_reg;
    assign stat.out_busy  = out_valid_reg && !m_tready;

    assign is_ins   = (req_reg == REQ_INSERT);
    assign is_rem   = (req_reg == REQ_REMOVE);
    assign is_known = is_ins || is_rem || (req_reg == REQ_LOOKUP);

    assign wr_en     = cmd.commit && is_ins && (hit_reg || free_reg);
    assign set_valid = cmd.commit && is_ins && !hit_reg && free_reg;
    assign clr_valid = cmd.commit && is_rem && hit_reg;
    assign wr_idx    = hit_reg ? hit_idx_reg : free_idx_reg;

    always_comb begin
        count_next = count_reg;
        if (set_valid) begin
            count_next = count_reg + CNT_W'(1);
        end else if (clr_valid) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign cnt_ext = {{COUNT_W{1'b0}}, count_next};

    // table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_idx] <= {val_reg, key_reg};
        end
        if (issue) begin
            rd_data_reg <= slot_mem[addr_reg[IDX_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            count_reg     <= '0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (set_valid) valid_reg[wr_idx] <= 1'b1;
            if (clr_valid) valid_reg[hit_idx_reg] <= 1'b0;
            count_reg <= count_next;

            if (cmd.load) begin
                addr_reg <= '0;
                pend_reg <= 1'b0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end else begin
                if (issue) addr_reg <= addr_reg + CNT_W'(1);
                pend_reg <= issue;
                if (pend_reg) begin
                    if (rd_vld_reg && (rd_data_reg[KEY_W-1:0] == key_reg)) hit_reg <= 1'b1;
                    if (!rd_vld_reg) free_reg <= 1'b1;
                end
            end

            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req_type;
            key_reg <= key;
            val_reg <= value_in;
        end
        if (issue) begin
            pend_idx_reg <= addr_reg[IDX_W-1:0];
            rd_vld_reg   <= valid_reg[addr_reg[IDX_W-1:0]];
        end
        if (pend_reg) begin
            if (rd_vld_reg && (rd_data_reg[KEY_W-1:0] == key_reg)) begin
                hit_idx_reg <= pend_idx_reg;
                hit_val_reg <= rd_data_reg[SLOT_W-1:KEY_W];
            end
            // lowest free slot wins
            if (!rd_vld_reg && !free_reg) begin
                free_idx_reg <= pend_idx_reg;
            end
        end
        if (cmd.commit) begin
            out_found_reg  <= hit_reg && is_known;
            out_value_reg  <= (hit_reg && is_known) ? hit_val_reg : '0;
            out_status_reg <= is_ins && !hit_reg && !free_reg;
            out_count_reg  <= cnt_ext[COUNT_W-1:0];
            out_empty_reg  <= (count_next == '0);
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign value_out   = out_value_reg;
    assign found       = out_found_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;
    assign is_empty    = out_empty_reg;

endmodule

/* src/key_value_table_top.sv */
// Key-value table with unique 32-bit keys and TABLE_ENTRIES slots. A request beat
// carries the operation in s_tuser (insert/update, lookup, remove) and key and value
// in s_tdata; each request gives exactly one result beat with the old or found
// value, a found flag, a full status for a refused insert, the entry count after
// the request (modulo 32) and an empty flag. A new key takes the lowest free slot.
// One request is handled at a time: the slot memory is swept one slot per cycle
// through its single read port, and the next request is accepted only after the
// table update of the last one. The result sits in an output register, so the next
// request's sweep overlaps a stalled result; only the table update waits for that
// register to free up.
module key_value_table_top
    import kvt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[31:0], value_in[63:32]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // value_out[31:0], found[32], status[33],
                                   // entry_count[38:34], is_empty[39]
);

    kvt_cmd_t  cmd;
    kvt_stat_t stat;

    logic [VALUE_W-1:0] value_out;
    logic               found;
    logic               status;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;

    kvt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kvt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (s_tuser),
        .key         (s_tdata[31:0]),
        .value_in    (s_tdata[63:32]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .value_out   (value_out),
        .found       (found),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    assign m_tdata = {is_empty, entry_count, status, found, value_out};

endmodule

/* tb/key_value_table_top_tb.sv */
`timescale 1ns / 100ps

module key_value_table_top_tb
    import kvt_pkg::*;
;

    localparam int SLOTS        = 16;
    localparam int RAND_REQS    = 1950;
    localparam int POOL_SIZE    = 24;   // more keys than slots, so the store can fill up
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PLAN_ROWS    = 25;

    // code the block must treat as a no-op
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               found;
        logic               full;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } kv_result_t;

    typedef struct {
        logic [REQ_W-1:0]   op;
        logic [KEY_W-1:0]   k;
        logic [VALUE_W-1:0] v;
        bit                 typed;
        kv_result_t         res;
    } kv_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // key[31:0], value_in[63:32]
    logic [1:0]  s_tuser;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // value_out[31:0], found[32], status[33],
                            // entry_count[38:34], is_empty[39]

    // shadow copy of the table
    logic               tbl_valid [SLOTS];
    logic [KEY_W-1:0]   tbl_key   [SLOTS];
    logic [VALUE_W-1:0] tbl_value [SLOTS];
    int                 tbl_count;

    kv_result_t         pending_results[$];
    kv_row_t            plan[PLAN_ROWS];
    int                 plan_len;
    logic [KEY_W-1:0]   key_pool[POOL_SIZE];
    int                 errors;
    int                 idle_cycles;
    bit                 no_gaps;
    kv_result_t         got;
    kv_result_t         want;

    key_value_table_top #(.TABLE_ENTRIES(SLOTS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic kv_result_t res(logic [VALUE_W-1:0] v, logic f, logic s,
                                       logic [COUNT_W-1:0] c, logic e);
        return {v, f, s, c, e};
    endfunction

    // updates the shadow table and returns the result the block should give
    function automatic kv_result_t apply_request(logic [REQ_W-1:0] op,
                                                 logic [KEY_W-1:0] k,
                                                 logic [VALUE_W-1:0] v);
        kv_result_t r;
        int hit;
        int free_slot;
        r = '0;
        hit = -1;
        free_slot = -1;
        for (int n = SLOTS - 1; n >= 0; n--) begin
            if (tbl_valid[n] && tbl_key[n] == k)
                hit = n;
            if (!tbl_valid[n])
                free_slot = n;
        end
        case (op)
            REQ_INSERT: begin
                if (hit >= 0) begin
                    r.value = tbl_value[hit];
                    r.found = 1'b1;
                    tbl_value[hit] = v;
                end else if (free_slot >= 0) begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_key[free_slot]   = k;
                    tbl_value[free_slot] = v;
                    tbl_count++;
                end else begin
                    r.full = 1'b1;
                end
            end
            REQ_LOOKUP: begin
                if (hit >= 0) begin
                    r.value = tbl_value[hit];
                    r.found = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (hit >= 0) begin
                    r.value = tbl_value[hit];
                    r.found = 1'b1;
                    tbl_valid[hit] = 1'b0;
                    tbl_count--;
                end
            end
            default: ;
        endcase
        r.count = tbl_count[COUNT_W-1:0];
        r.empty = (tbl_count == 0);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    task automatic add_row(logic [REQ_W-1:0] op, logic [KEY_W-1:0] k,
                           logic [VALUE_W-1:0] v, bit typed, kv_result_t r);
        plan[plan_len] = '{op, k, v, typed, r};
        plan_len++;
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_request(logic [REQ_W-1:0] op, logic [KEY_W-1:0] k,
                                logic [VALUE_W-1:0] v, bit typed, kv_result_t typed_res);
        int gap;
        kv_result_t predicted;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v, k};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        predicted = apply_request(op, k, v);
        pending_results.push_back(typed ? typed_res : predicted);
        @(negedge aclk);
    endtask

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[38:34], m_tdata[39]};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("value_out", want.value, got.value);
                check_field("found", 32'(want.found), 32'(got.found));
                check_field("status", 32'(want.full), 32'(got.full));
                check_field("entry_count", 32'(want.count), 32'(got.count));
                check_field("is_empty", 32'(want.empty), 32'(got.empty));
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: ready bursts, some of them long, broken by stalls
    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 12))
                @(negedge aclk);
            n = pick_gap();
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
        end
    end

    initial begin
        logic [REQ_W-1:0]   op;
        logic [KEY_W-1:0]   k;
        int                 r;
        bit                 fill_bias;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        errors      = 0;
        idle_cycles = 0;
        no_gaps     = 1'b0;
        plan_len    = 0;
        tbl_count   = 0;
        for (int n = 0; n < SLOTS; n++) begin
            tbl_valid[n] = 1'b0;
            tbl_key[n]   = '0;
            tbl_value[n] = '0;
        end

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h7FFF_FFFF;
        for (int n = 4; n < POOL_SIZE; n++)
            key_pool[n] = $urandom;

        // misses and the unused code on an empty table
        add_row(REQ_LOOKUP, 32'h0000_0000, 32'h0, 1'b1, res(32'h0, 1'b0, 1'b0, 5'd0, 1'b1));
        add_row(REQ_REMOVE, 32'h7FFF_FFFF, 32'h0, 1'b1, res(32'h0, 1'b0, 1'b0, 5'd0, 1'b1));
        add_row(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                res(32'h0, 1'b0, 1'b0, 5'd0, 1'b1));
        // insert, overwrite, lookup and remove at the extremes
        add_row(REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                res(32'h0, 1'b0, 1'b0, 5'd1, 1'b0));
        add_row(REQ_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b1,
                res(32'h7FFF_FFFF, 1'b1, 1'b0, 5'd1, 1'b0));
        add_row(REQ_LOOKUP, 32'h8000_0000, 32'h0, 1'b1,
                res(32'h8000_0000, 1'b1, 1'b0, 5'd1, 1'b0));
        add_row(REQ_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(REQ_REMOVE, 32'h8000_0000, 32'h0, 1'b1,
                res(32'h8000_0000, 1'b1, 1'b0, 5'd1, 1'b0));
        // reuses the slot just freed
        add_row(REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, '0);
        for (int n = 1; n <= SLOTS - 2; n++)
            add_row(REQ_INSERT, n, 32'h1000_0000 + n, 1'b0, '0);
        // full table: new key refused, present key still updated
        add_row(REQ_INSERT, 32'h0000_000F, 32'h1234_5678, 1'b1,
                res(32'h0, 1'b0, 1'b1, 5'd16, 1'b0));
        add_row(REQ_INSERT, 32'h0000_0000, 32'h0000_0005, 1'b1,
                res(32'h0, 1'b1, 1'b0, 5'd16, 1'b0));

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int n = 0; n < plan_len; n++)
            send_request(plan[n].op, plan[n].k, plan[n].v, plan[n].typed, plan[n].res);

        // random part: alternating fill and drain phases over a small key pool
        fill_bias = 1'b0;
        for (int n = 0; n < RAND_REQS; n++) begin
            if (n % 150 == 0)
                fill_bias = ~fill_bias;
            no_gaps = (n % 250) < 30;
            r = $urandom_range(0, 99);
            if (r < 3)
                op = REQ_UNUSED;
            else if (fill_bias)
                op = (r < 68) ? REQ_INSERT : (r < 88) ? REQ_LOOKUP : REQ_REMOVE;
            else
                op = (r < 30) ? REQ_INSERT : (r < 55) ? REQ_LOOKUP : REQ_REMOVE;
            k = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_request(op, k, $urandom, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
